// ===== rtl/core/lru_k_frame_replacer_top_macros.svh =====
// assertion macros for the lru-k frame replacer
`ifndef LRU_K_FRAME_REPLACER_TOP_MACROS_SVH
`define LRU_K_FRAME_REPLACER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define LKFR_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define LKFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LKFR_ASSERT_ALWAYS(label, expr)
`define LKFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/lkfr_pkg.sv =====
// shared codes and field widths of the lru-k frame replacer
package lkfr_pkg;
  localparam int CmdW    = 2;
  localparam int FrameW  = 8;
  localparam int StatusW = 3;
  localparam int VictimW = 6;
  localparam int CountW  = 7;
  localparam int KRegW   = 4;
  localparam int NRegW   = 7;

  localparam logic [CmdW-1:0] CMD_RECORD = 2'd0;
  localparam logic [CmdW-1:0] CMD_SETEV  = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CmdW-1:0] CMD_EVICT  = 2'd3;

  localparam logic [StatusW-1:0] ST_OK            = 3'd0;
  localparam logic [StatusW-1:0] ST_EVICTED       = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY         = 3'd2;
  localparam logic [StatusW-1:0] ST_INVALID       = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_EVICTABLE = 3'd4;

  localparam logic REG_K      = 1'b0;
  localparam logic REG_FRAMES = 1'b1;
endpackage

// ===== rtl/core/lkfr_ram.sv =====
// simple dual-port ram with registered read
module lkfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lru_k_frame_replacer_top.sv =====
// top level of the lru-k frame replacer: command sequencer and victim scan
//
// channel  direction  handshake           payload
// s_*      in         s_tvalid/s_tready   tuser cmd, tdata frame, evictable_flag
// m_*      out        m_tvalid/m_tready   tuser status, tdata victim, evictable count
// cfg_*    in         cfg_we              cfg_index, cfg_data
//
// one command at a time; record does a meta read, then a read-modify-write
// set evictable, remove and invalid ids finish in the decode state
// evict scans every frame through the meta and history rams
// a waiting result holds the sequencer; reset clears marks and the clock at once
`include "lru_k_frame_replacer_top_macros.svh"
module lru_k_frame_replacer_top #(
  parameter int FRAMES = 64,
  parameter int MAX_K = 8,
  parameter int TIME_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] frame, [8] evictable_flag
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] victim_frame, [12:6] evictable_count
  output logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LW = $clog2(MAX_K + 1);
  localparam int HW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int MW = HW + LW;
  localparam int AW = (FRAMES * MAX_K > 1) ? $clog2(FRAMES * MAX_K) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_WR, S_SCAN, S_DONE} state_t;

  state_t state;
  logic [lkfr_pkg::KRegW-1:0] cfg_k;
  logic [lkfr_pkg::NRegW-1:0] cfg_frames;
  logic [lkfr_pkg::CmdW-1:0]  cmd_q;
  logic [lkfr_pkg::FrameW-1:0] fid_q;
  logic                       flag_q;
  logic [FRAMES-1:0]          tracked;
  logic [FRAMES-1:0]          ev;
  logic [CW-1:0]              cnt;
  logic [TIME_BITS-1:0]       aclk;
  logic [lkfr_pkg::StatusW-1:0] st_q;
  logic [FW-1:0]              vic_q;

  // result word register
  logic [lkfr_pkg::StatusW-1:0] res_status;
  logic [FW-1:0]                res_victim;
  logic [CW-1:0]                res_count;

  // scan pipeline
  logic [FW:0]          sc;
  logic                 v1, c1, v2, c2, inf2, z2;
  logic [FW-1:0]        f1, f2;
  logic                 found, binf;
  logic [TIME_BITS-1:0] btime;
  logic [FW-1:0]        best;

  // ram ports
  logic          meta_we;
  logic [FW-1:0] meta_raddr;
  logic [MW-1:0] meta_wdata, meta_rdata;
  logic          t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [TIME_BITS-1:0] t_rdata;

  function automatic logic [HW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LW+1)'(MAX_K)) begin
      s = s - (LW+1)'(MAX_K);
    end
    return HW'(s);
  endfunction

  // effective k and frame limit
  logic [LW-1:0] kk;
  logic [10:0]   lim;
  always_comb begin
    if (cfg_k == '0) begin
      kk = LW'(1);
    end else if ({1'b0, cfg_k} > 5'(MAX_K)) begin
      kk = LW'(MAX_K);
    end else begin
      kk = LW'(cfg_k);
    end
    lim = (11'(cfg_frames) > 11'(FRAMES)) ? 11'(FRAMES) : 11'(cfg_frames);
  end

  logic invalid;
  logic [FW-1:0] fq;
  assign invalid = 11'(fid_q) >= lim;
  assign fq = FW'(fid_q);

  // record: new head and length of the circular history
  logic [HW-1:0] m_head;
  logic [LW-1:0] m_len, c_len, n_len, drop;
  logic [HW-1:0] c_head, n_head;
  logic [TIME_BITS-1:0] aclk_next;
  assign m_head = meta_rdata[MW-1:LW];
  assign m_len  = meta_rdata[LW-1:0];
  always_comb begin
    c_len  = tracked[fq] ? m_len : '0;
    c_head = tracked[fq] ? m_head : '0;
    drop   = c_len - kk + LW'(1);
    if (c_len >= kk) begin
      n_head = add_mod(LW'(c_head), drop);
      n_len  = kk - LW'(1);
    end else begin
      n_head = c_head;
      n_len  = c_len;
    end
    aclk_next = (aclk == '1) ? aclk : aclk + TIME_BITS'(1);
  end

  // scan stage one: address of the k-distance stamp
  logic          minf;
  logic [LW-1:0] midx;
  assign minf = m_len < kk;
  assign midx = minf ? '0 : m_len - kk;

  always_comb begin
    meta_raddr = (state == S_SCAN) ? sc[FW-1:0] : fq;
    meta_we    = (state == S_WR);
    meta_wdata = {n_head, n_len + LW'(1)};
    t_we       = (state == S_WR);
    t_waddr    = AW'(fq) * AW'(MAX_K) + AW'(add_mod(LW'(n_head), n_len));
    t_raddr    = AW'(f1) * AW'(MAX_K) + AW'(add_mod(LW'(m_head), midx));
  end

  // scan stage two: candidate stamp
  logic [TIME_BITS-1:0] ctime;
  logic                 better;
  assign ctime  = z2 ? '0 : t_rdata;
  assign better = !found || (inf2 && !binf) || (inf2 == binf && ctime < btime);

  assign s_tready = (state == S_IDLE);
  assign m_tuser  = res_status;
  assign m_tdata  = {3'b000, 7'(res_count), 6'(res_victim)};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k      <= lkfr_pkg::KRegW'(2);
      cfg_frames <= lkfr_pkg::NRegW'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lkfr_pkg::REG_K:      cfg_k <= cfg_data[lkfr_pkg::KRegW-1:0];
        lkfr_pkg::REG_FRAMES: cfg_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // result word register, holds while the receiver waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid   <= 1'b1;
      res_status <= st_q;
      res_victim <= vic_q;
      res_count  <= cnt;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tracked  <= '0;
      ev       <= '0;
      cnt      <= '0;
      aclk     <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      found    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= s_tuser;
            fid_q  <= s_tdata[7:0];
            flag_q <= s_tdata[8];
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          vic_q <= '0;
          if (cmd_q == lkfr_pkg::CMD_EVICT) begin
            st_q  <= lkfr_pkg::ST_OK;
            sc    <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else if (invalid) begin
            st_q  <= lkfr_pkg::ST_INVALID;
            state <= S_DONE;
          end else begin
            unique case (cmd_q)
              lkfr_pkg::CMD_RECORD: begin
                st_q  <= lkfr_pkg::ST_OK;
                state <= S_WR;
              end
              lkfr_pkg::CMD_SETEV: begin
                st_q  <= lkfr_pkg::ST_OK;
                state <= S_DONE;
                if (tracked[fq] && ev[fq] != flag_q) begin
                  ev[fq] <= flag_q;
                  if (flag_q) cnt <= cnt + CW'(1);
                  else if (cnt != '0) cnt <= cnt - CW'(1);
                end
              end
              default: begin
                state <= S_DONE;
                if (tracked[fq] && !ev[fq]) begin
                  st_q <= lkfr_pkg::ST_NOT_EVICTABLE;
                end else begin
                  st_q <= lkfr_pkg::ST_OK;
                  if (tracked[fq]) begin
                    tracked[fq] <= 1'b0;
                    ev[fq]      <= 1'b0;
                    if (cnt != '0) cnt <= cnt - CW'(1);
                  end
                end
              end
            endcase
          end
        end
        S_WR: begin
          if (!tracked[fq]) ev[fq] <= 1'b0;
          tracked[fq] <= 1'b1;
          aclk        <= aclk_next;
          state       <= S_DONE;
        end
        S_SCAN: begin
          // issue one frame per cycle
          if (sc < (FW+1)'(FRAMES)) begin
            v1 <= 1'b1;
            f1 <= sc[FW-1:0];
            c1 <= tracked[sc[FW-1:0]] & ev[sc[FW-1:0]];
            sc <= sc + (FW+1)'(1);
          end else begin
            v1 <= 1'b0;
          end
          v2   <= v1;
          c2   <= c1;
          f2   <= f1;
          inf2 <= minf;
          z2   <= (m_len == '0);
          if (v2 && c2 && better) begin
            found <= 1'b1;
            binf  <= inf2;
            btime <= ctime;
            best  <= f2;
          end
          if (sc == (FW+1)'(FRAMES) && !v1 && !v2) begin
            state <= S_DONE;
            if (found) begin
              tracked[best] <= 1'b0;
              ev[best]      <= 1'b0;
              if (cnt != '0) cnt <= cnt - CW'(1);
              st_q  <= lkfr_pkg::ST_EVICTED;
              vic_q <= best;
            end else begin
              st_q <= lkfr_pkg::ST_EMPTY;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  lkfr_ram #(.WIDTH(MW), .DEPTH(FRAMES), .AW(FW)) u_meta (
    .clk(clk), .we(meta_we), .waddr(fq), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  lkfr_ram #(.WIDTH(TIME_BITS), .DEPTH(FRAMES * MAX_K), .AW(AW)) u_times (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(aclk_next),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  // evictable count tracks the marks, marks only on tracked frames
  `LKFR_ASSERT_ALWAYS(a_cnt_matches, 32'(cnt) == 32'($countones(ev)))
  `LKFR_ASSERT_ALWAYS(a_ev_tracked, (ev & ~tracked) == '0)
  `LKFR_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state == S_DEC)
endmodule

// ===== tb/lru_k_frame_replacer_top_test.sv =====
// self-checking testbench for the lru-k frame replacer top level
module lru_k_frame_replacer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = 64;
  localparam int DEPTH_MAX = 8;
  localparam int STAMP_W = 48;
  localparam int CYCLE_LIMIT = 2000000;
  // an evict scans every frame, so let the scan finish before a register write
  localparam int SETTLE = NFRAMES + 20;

  typedef struct packed {
    logic [lkfr_pkg::StatusW-1:0] status;
    logic [lkfr_pkg::VictimW-1:0] victim;
    logic [lkfr_pkg::CountW-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [lkfr_pkg::CmdW-1:0]    cmd;
    logic [lkfr_pkg::FrameW-1:0]  frame;
    logic                         flag;
    logic                         typed;
    logic [lkfr_pkg::StatusW-1:0] status;
    logic [lkfr_pkg::VictimW-1:0] victim;
    logic [lkfr_pkg::CountW-1:0]  count;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;   // [7:0] frame, [8] evictable_flag
  logic [1:0]        s_tuser;   // [1:0] cmd
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;   // [5:0] victim_frame, [12:6] evictable_count
  logic [2:0]        m_tuser;   // [2:0] status
  logic              cfg_we;
  logic              cfg_index;
  logic [6:0]        cfg_data;

  lru_k_frame_replacer_top uut (.*);

  // pool model
  logic [lkfr_pkg::KRegW-1:0] depth_reg;
  logic [lkfr_pkg::NRegW-1:0] frames_reg;
  bit                 is_tracked [NFRAMES];
  bit                 ev_mark [NFRAMES];
  int                 hist_len [NFRAMES];
  logic [STAMP_W-1:0] hist_stamp [NFRAMES][DEPTH_MAX];
  logic [STAMP_W-1:0] stamp_now;
  int                 evictable_cnt;

  outcome_t pending_results[$];
  int       errors = 0;
  int       words_checked = 0;
  int       cycles = 0;
  bit       steady = 0;

  // opening rows: empty pool, invalid ids, untracked frames, non-evictable remove
  directed_row_t directed [21] = '{
    '{lkfr_pkg::CMD_EVICT,  8'd0,   1'b0, 1'b1, lkfr_pkg::ST_EMPTY,         6'd0, 7'd0},
    '{lkfr_pkg::CMD_RECORD, 8'd0,   1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_RECORD, 8'd255, 1'b1, 1'b1, lkfr_pkg::ST_INVALID,       6'd0, 7'd0},
    '{lkfr_pkg::CMD_SETEV,  8'd64,  1'b1, 1'b1, lkfr_pkg::ST_INVALID,       6'd0, 7'd0},
    '{lkfr_pkg::CMD_SETEV,  8'd7,   1'b1, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_REMOVE, 8'd7,   1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_RECORD, 8'd63,  1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_RECORD, 8'd0,   1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_RECORD, 8'd1,   1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_SETEV,  8'd0,   1'b1, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd1},
    '{lkfr_pkg::CMD_SETEV,  8'd63,  1'b1, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd2},
    '{lkfr_pkg::CMD_SETEV,  8'd1,   1'b1, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd3},
    '{lkfr_pkg::CMD_RECORD, 8'd5,   1'b0, 1'b1, lkfr_pkg::ST_OK,            6'd0, 7'd3},
    '{lkfr_pkg::CMD_REMOVE, 8'd5,   1'b0, 1'b1, lkfr_pkg::ST_NOT_EVICTABLE, 6'd0, 7'd3},
    '{lkfr_pkg::CMD_EVICT,  8'd170, 1'b1, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_SETEV,  8'd1,   1'b0, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_REMOVE, 8'd0,   1'b0, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_SETEV,  8'd5,   1'b1, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_EVICT,  8'd0,   1'b0, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_EVICT,  8'd85,  1'b0, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0},
    '{lkfr_pkg::CMD_REMOVE, 8'd128, 1'b1, 1'b0, lkfr_pkg::ST_OK,            6'd0, 7'd0}
  };

  // apply one command to the pool model and return its result word
  function automatic outcome_t apply_command(logic [lkfr_pkg::CmdW-1:0] cmd,
                                             logic [lkfr_pkg::FrameW-1:0] f,
                                             logic flag);
    outcome_t           o;
    int                 k;
    int                 lim;
    int                 len;
    int                 drop;
    int                 best;
    bit                 found;
    bit                 best_inf;
    bit                 inf;
    logic [STAMP_W-1:0] best_t;
    logic [STAMP_W-1:0] t;
    o = '0;
    o.status = lkfr_pkg::ST_OK;
    k = (depth_reg < 1) ? 1 : (depth_reg > DEPTH_MAX) ? DEPTH_MAX : depth_reg;
    lim = (frames_reg > NFRAMES) ? NFRAMES : frames_reg;
    if (cmd == lkfr_pkg::CMD_EVICT) begin
      found = 0;
      best_inf = 0;
      best_t = '0;
      best = 0;
      // frames short of k accesses first, then the oldest k-th access
      for (int i = 0; i < NFRAMES; i++) begin
        if (!is_tracked[i] || !ev_mark[i]) continue;
        len = hist_len[i];
        inf = len < k;
        if (inf) t = (len != 0) ? hist_stamp[i][0] : '0;
        else t = hist_stamp[i][len - k];
        if (!found || (inf && !best_inf) || (inf == best_inf && t < best_t)) begin
          found = 1;
          best_inf = inf;
          best_t = t;
          best = i;
        end
      end
      if (found) begin
        is_tracked[best] = 0;
        ev_mark[best] = 0;
        hist_len[best] = 0;
        if (evictable_cnt > 0) evictable_cnt--;
        o.status = lkfr_pkg::ST_EVICTED;
        o.victim = best[lkfr_pkg::VictimW-1:0];
      end else begin
        o.status = lkfr_pkg::ST_EMPTY;
      end
    end else if (f >= lim) begin
      o.status = lkfr_pkg::ST_INVALID;
    end else if (cmd == lkfr_pkg::CMD_RECORD) begin
      len = hist_len[f];
      if (stamp_now != '1) stamp_now++;
      if (!is_tracked[f]) begin
        is_tracked[f] = 1;
        ev_mark[f] = 0;
        len = 0;
      end
      // keep only the k most recent stamps
      if (len >= k) begin
        drop = len - k + 1;
        for (int i = 0; i < len - drop; i++) hist_stamp[f][i] = hist_stamp[f][i + drop];
        len -= drop;
      end
      hist_stamp[f][len] = stamp_now;
      hist_len[f] = len + 1;
    end else if (cmd == lkfr_pkg::CMD_SETEV) begin
      if (is_tracked[f] && ev_mark[f] != flag) begin
        ev_mark[f] = flag;
        if (flag) evictable_cnt++;
        else if (evictable_cnt > 0) evictable_cnt--;
      end
    end else begin
      if (is_tracked[f]) begin
        if (!ev_mark[f]) begin
          o.status = lkfr_pkg::ST_NOT_EVICTABLE;
        end else begin
          is_tracked[f] = 0;
          ev_mark[f] = 0;
          hist_len[f] = 0;
          if (evictable_cnt > 0) evictable_cnt--;
        end
      end
    end
    o.count = evictable_cnt[lkfr_pkg::CountW-1:0];
    return o;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one command word and wait for it to be taken
  task automatic send_word(logic [lkfr_pkg::CmdW-1:0] cmd, logic [lkfr_pkg::FrameW-1:0] f,
                           logic flag, bit typed, outcome_t typed_res);
    outcome_t o;
    int       gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {7'b0, flag, f};
    do @(posedge clk); while (!s_tready);
    o = apply_command(cmd, f, flag);
    pending_results.insert(pending_results.size(), typed ? typed_res : o);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // registers change only once the block has drained
  task automatic write_reg(logic idx, logic [6:0] val);
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == lkfr_pkg::REG_K) depth_reg = val[lkfr_pkg::KRegW-1:0];
    else frames_reg = val;
  endtask

  task automatic random_phase(logic [6:0] k, logic [6:0] n, int count);
    int                          lim;
    int                          r;
    logic [lkfr_pkg::CmdW-1:0]   cmd;
    logic [lkfr_pkg::FrameW-1:0] f;
    write_reg(lkfr_pkg::REG_K, k);
    write_reg(lkfr_pkg::REG_FRAMES, n);
    lim = (frames_reg > NFRAMES) ? NFRAMES : frames_reg;
    for (int i = 0; i < count; i++) begin
      steady = (i >= 40 && i < 80);
      r = $urandom_range(0, 99);
      if (r < 40) cmd = lkfr_pkg::CMD_RECORD;
      else if (r < 68) cmd = lkfr_pkg::CMD_SETEV;
      else if (r < 80) cmd = lkfr_pkg::CMD_REMOVE;
      else cmd = lkfr_pkg::CMD_EVICT;
      if (lim > 0 && $urandom_range(0, 99) < 85) f = $urandom_range(0, lim - 1);
      else f = $urandom_range(0, 255);
      send_word(cmd, f, ($urandom_range(0, 9) < 6), 0, '0);
    end
    steady = 0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // stimulus
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    depth_reg = 4'd2;
    frames_reg = 7'd64;
    stamp_now = '0;
    evictable_cnt = 0;
    for (int i = 0; i < NFRAMES; i++) begin
      is_tracked[i] = 0;
      ev_mark[i] = 0;
      hist_len[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      send_word(directed[i].cmd, directed[i].frame, directed[i].flag, directed[i].typed,
                '{directed[i].status, directed[i].victim, directed[i].count});

    random_phase(7'd2, 7'd64, 250);
    random_phase(7'd1, 7'd64, 200);
    random_phase(7'd8, 7'd64, 250);
    // lowered k with long histories left in place
    random_phase(7'd3, 7'd64, 150);
    random_phase(7'd0, 7'd1, 100);
    random_phase(7'd15, 7'd127, 200);
    random_phase(7'd4, 7'd0, 40);
    random_phase(7'd5, 7'd12, 200);
    random_phase(7'd2, 7'd64, 200);

    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // result side backpressure, with one long hold to fill the block
  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_checked >= 150) begin
        held = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (((words_checked / 100) % 4) != 1 && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
      @(negedge clk);
    end
  end

  // compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d", m_tuser);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_tuser !== want.status) begin
          $error("status expected %0d got %0d", want.status, m_tuser);
          errors++;
        end
        if (m_tdata[5:0] !== want.victim) begin
          $error("victim_frame expected %0d got %0d", want.victim, m_tdata[5:0]);
          errors++;
        end
        if (m_tdata[12:6] !== want.count) begin
          $error("evictable_count expected %0d got %0d", want.count, m_tdata[12:6]);
          errors++;
        end
      end
      words_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule

// ===== lru_k_frame_replacer_top.f =====
+incdir+rtl/core
rtl/core/lkfr_pkg.sv
rtl/core/lkfr_ram.sv
rtl/core/lru_k_frame_replacer_top.sv
tb/lru_k_frame_replacer_top_test.sv
